FILE: design/mpjs_pkg.sv
// Shared types, codes and compare functions for the multi-policy job scheduler.
// Used by mpjs_slot_mem and multi_policy_job_scheduler_core; depends on nothing.
package mpjs_pkg;

  // Default size of the ready-job table.
  localparam int QUEUE_DEPTH_DEF = 16;

  // Slot numbers are compared at this width, wide enough for a full table plus one.
  localparam int SLOT_CMP_W = 9;

  localparam int POLICY_W = 3;
  localparam int ADDR_W   = 2;
  localparam int SUM_W    = 48;

  // Configuration register byte addresses.
  localparam logic [ADDR_W-1:0] ADDR_POLICY = 2'd0;

  // Policy codes; the two unused codes behave as first come, first served.
  localparam logic [POLICY_W-1:0] POL_FCFS  = 3'd0;
  localparam logic [POLICY_W-1:0] POL_PRIO  = 3'd1;
  localparam logic [POLICY_W-1:0] POL_PPRIO = 3'd2;
  localparam logic [POLICY_W-1:0] POL_SRTF  = 3'd3;
  localparam logic [POLICY_W-1:0] POL_RR    = 3'd4;
  localparam logic [POLICY_W-1:0] POL_SJF   = 3'd5;

  // Request opcodes.
  localparam logic [1:0] OP_ARRIVE   = 2'd0;
  localparam logic [1:0] OP_DISPATCH = 2'd1;
  localparam logic [1:0] OP_FINISH   = 2'd2;

  // One job record as kept in the table and in the running register.
  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  pri;
    logic [15:0] rt;
    logic [31:0] arr;
    logic [15:0] rem;
    logic [31:0] start;
    logic [31:0] seq;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHARGE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_START,
    ST_ARRIVE,
    ST_FIN_A,
    ST_FIN_B,
    ST_DONE
  } state_t;

  function automatic logic is_preemptive(logic [POLICY_W-1:0] pol);
    return (pol == POL_PPRIO) || (pol == POL_SRTF) || (pol == POL_RR);
  endfunction

  // Primary ordering key of a job under the given policy.
  function automatic logic [31:0] key_of(job_t j, logic [POLICY_W-1:0] pol);
    logic [31:0] k;
    case (pol)
      POL_PRIO, POL_PPRIO: k = {24'd0, j.pri};
      POL_SRTF:            k = {16'd0, j.rem};
      POL_RR:              k = j.seq;
      POL_SJF:             k = {16'd0, j.rt};
      default:             k = 32'd0;
    endcase
    return k;
  endfunction

  // True when job a in slot sa is served ahead of job b in slot sb.
  function automatic logic served_first(job_t a, logic [SLOT_CMP_W-1:0] sa,
                                        job_t b, logic [SLOT_CMP_W-1:0] sb,
                                        logic [POLICY_W-1:0] pol);
    logic [31:0] ka;
    logic [31:0] kb;
    logic        r;
    ka = key_of(a, pol);
    kb = key_of(b, pol);
    if (ka != kb) begin
      r = ka < kb;
    end else if (a.arr != b.arr) begin
      r = a.arr < b.arr;
    end else begin
      r = sa < sb;
    end
    return r;
  endfunction

endpackage

FILE: design/mpjs_slot_mem.sv
// Job table storage: one write port and one registered read port.
// Depends on mpjs_pkg for the job record type.
module mpjs_slot_mem #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  mpjs_pkg::job_t   wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output mpjs_pkg::job_t   rd_data
);
  import mpjs_pkg::*;

  job_t mem [DEPTH];

  // Write and registered read share one clocked block.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: design/multi_policy_job_scheduler_core.sv
// Multi-policy job scheduler: a table of ready jobs, one running job and finish totals.
// Uses mpjs_pkg and the table memory mpjs_slot_mem.
//
// The block takes no new request until it is through with the previous one.
// An arrival scans the whole table through the memory's single read port, one slot
// a cycle, then writes the new job into the first free slot or flags a full table.
// A dispatch point charges the running job, scans the table, then decides and starts
// the winner; under a policy that lets the running job keep the CPU it makes no scan.
// A finish runs through ST_FIN_A and ST_FIN_B; other codes go straight to the result.
// A result that is not taken stalls the block until it is. No clearing pass is needed
// after reset.
module multi_policy_job_scheduler_core #(
  parameter int QUEUE_DEPTH = mpjs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Request channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_op,
  input  logic [15:0]                  in_job_id,
  input  logic [7:0]                   in_job_priority,
  input  logic [15:0]                  in_run_time,
  input  logic [31:0]                  in_now,
  // Result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_dispatch_valid,
  output logic [15:0]                  out_dispatch_id,
  output logic                         out_table_full,
  output logic [15:0]                  out_finished_count,
  output logic [mpjs_pkg::SUM_W-1:0]   out_total_turnaround,
  output logic [mpjs_pkg::SUM_W-1:0]   out_total_wait,
  output logic [mpjs_pkg::SUM_W-1:0]   out_total_response,
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mpjs_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import mpjs_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [SLOT_CMP_W-1:0] NO_SLOT = SLOT_CMP_W'(QUEUE_DEPTH);
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  state_t state_r, state_nxt;

  logic [POLICY_W-1:0]  policy_r;
  logic [1:0]           op_r;
  logic [15:0]          id_r;
  logic [7:0]           pri_r;
  logic [15:0]          rt_r;
  logic [31:0]          now_r;

  logic [QUEUE_DEPTH-1:0] valid_r;
  logic                 run_valid_r;
  job_t                 run_rec_r;
  logic                 last_valid_r;
  logic [31:0]          last_time_r;
  logic [31:0]          next_seq_r;
  logic [15:0]          done_cnt_r;
  logic [SUM_W-1:0]     sum_ta_r;
  logic [SUM_W-1:0]     sum_wt_r;
  logic [SUM_W-1:0]     sum_rs_r;

  logic [IDX_W-1:0]     idx_r;
  logic                 cmp_vld_r;
  logic [IDX_W-1:0]     cmp_idx_r;
  logic                 best_found_r;
  logic [IDX_W-1:0]     best_idx_r;
  job_t                 best_rec_r;
  logic                 free_found_r;
  logic [IDX_W-1:0]     free_idx_r;

  logic                 dv_r;
  logic [15:0]          did_r;
  logic                 tf_r;
  logic [31:0]          ta_r;
  logic [31:0]          rs_r;

  logic                 out_valid_r;

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  job_t                 mem_wdata;
  job_t                 mem_rdata;

  logic [31:0]          elapsed;
  logic [15:0]          rem_charged;
  job_t                 run_charged;
  logic [QUEUE_DEPTH-1:0] valid_decide;
  logic                 run_wins;
  logic                 take_best;
  logic                 cand_better;
  logic [31:0]          wt_val;
  logic [SUM_W:0]       ta_sum;
  logic [SUM_W:0]       wt_sum;
  logic [SUM_W:0]       rs_sum;
  job_t                 new_job;

  // Table payload memory.
  mpjs_slot_mem #(
    .DEPTH (QUEUE_DEPTH),
    .IDX_W (IDX_W)
  ) u_slot_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (idx_r),
    .rd_data (mem_rdata)
  );

  // Configuration port: always ready, one register.
  assign pready = 1'b1;
  assign prdata = {{(32 - POLICY_W){1'b0}}, policy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_FCFS;
    end else if (psel && penable && pwrite && paddr == ADDR_POLICY) begin
      policy_r <= pwdata[POLICY_W-1:0];
    end
  end

  // Charge the running job for the ticks since the previous dispatch point.
  always_comb begin
    elapsed = (now_r >= last_time_r) ? now_r - last_time_r : 32'd0;
    rem_charged = (elapsed >= {16'd0, run_rec_r.rem}) ? 16'd0
                : run_rec_r.rem - elapsed[15:0];
  end

  // Running record after the charge; a preempted job re-queues with a fresh sequence number.
  always_comb begin
    run_charged = run_rec_r;
    if (run_valid_r && last_valid_r) begin
      run_charged.rem = rem_charged;
    end
    if (run_valid_r && is_preemptive(policy_r)) begin
      run_charged.seq = next_seq_r;
    end
  end

  // Compare logic: scanned slot against the best so far, and running job
  // against the winner of the scan.
  always_comb begin
    cand_better = !best_found_r
               || served_first(mem_rdata, SLOT_CMP_W'(cmp_idx_r),
                               best_rec_r, SLOT_CMP_W'(best_idx_r), policy_r);
    run_wins = run_valid_r
            && (!best_found_r
                || served_first(run_rec_r,
                                free_found_r ? SLOT_CMP_W'(free_idx_r) : NO_SLOT,
                                best_rec_r, SLOT_CMP_W'(best_idx_r), policy_r));
    take_best = !run_wins && best_found_r;
  end

  // Table occupancy after a decision: the winner leaves, a preempted job takes a
  // free slot or the winner's place.
  always_comb begin
    valid_decide = valid_r;
    valid_decide[best_idx_r] = 1'b0;
    if (run_valid_r) begin
      valid_decide[free_found_r ? free_idx_r : best_idx_r] = 1'b1;
    end
  end

  // Finish arithmetic: wait and saturating totals.
  always_comb begin
    wt_val = (ta_r >= {16'd0, run_rec_r.rt}) ? ta_r - {16'd0, run_rec_r.rt} : 32'd0;
    ta_sum = {1'b0, sum_ta_r} + {{(SUM_W - 31){1'b0}}, ta_r};
    wt_sum = {1'b0, sum_wt_r} + {{(SUM_W - 31){1'b0}}, wt_val};
    rs_sum = {1'b0, sum_rs_r} + {{(SUM_W - 31){1'b0}}, rs_r};
  end

  // Record of an arriving job.
  always_comb begin
    new_job.id    = id_r;
    new_job.pri   = pri_r;
    new_job.rt    = rt_r;
    new_job.arr   = now_r;
    new_job.rem   = rt_r;
    new_job.start = 32'd0;
    new_job.seq   = next_seq_r;
  end

  // Table write port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = free_idx_r;
    mem_wdata = new_job;
    case (state_r)
      ST_ARRIVE: begin
        mem_we = free_found_r;
      end
      ST_DECIDE: begin
        mem_we    = take_best && run_valid_r;
        mem_waddr = free_found_r ? free_idx_r : best_idx_r;
        mem_wdata = run_rec_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_ARRIVE:   state_nxt = ST_SCAN;
            OP_DISPATCH: state_nxt = ST_CHARGE;
            OP_FINISH:   state_nxt = ST_FIN_A;
            default:     state_nxt = ST_DONE;
          endcase
        end
      end
      ST_CHARGE: begin
        state_nxt = (run_valid_r && !is_preemptive(policy_r)) ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = (op_r == OP_ARRIVE) ? ST_ARRIVE : ST_DECIDE;
      end
      ST_DECIDE: state_nxt = ST_START;
      ST_START:  state_nxt = ST_DONE;
      ST_ARRIVE: state_nxt = ST_DONE;
      ST_FIN_A:  state_nxt = ST_FIN_B;
      ST_FIN_B:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    out_valid = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer datapath and scheduler state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      run_valid_r  <= 1'b0;
      run_rec_r    <= '0;
      last_valid_r <= 1'b0;
      last_time_r  <= 32'd0;
      next_seq_r   <= 32'd0;
      done_cnt_r   <= 16'd0;
      sum_ta_r     <= '0;
      sum_wt_r     <= '0;
      sum_rs_r     <= '0;
      cmp_vld_r    <= 1'b0;
      best_found_r <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // Compare the slot read in the previous cycle.
      if (cmp_vld_r && valid_r[cmp_idx_r] && cand_better) begin
        best_found_r <= 1'b1;
        best_idx_r   <= cmp_idx_r;
        best_rec_r   <= mem_rdata;
      end

      if (out_valid_r && out_ready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            op_r         <= in_op;
            id_r         <= in_job_id;
            pri_r        <= in_job_priority;
            rt_r         <= in_run_time;
            now_r        <= in_now;
            dv_r         <= 1'b0;
            did_r        <= 16'd0;
            tf_r         <= 1'b0;
            idx_r        <= '0;
            cmp_vld_r    <= 1'b0;
            best_found_r <= 1'b0;
            free_found_r <= 1'b0;
          end
        end
        ST_CHARGE: begin
          run_rec_r    <= run_charged;
          last_time_r  <= now_r;
          last_valid_r <= 1'b1;
          if (run_valid_r && !is_preemptive(policy_r)) begin
            dv_r  <= 1'b1;
            did_r <= run_rec_r.id;
          end else if (run_valid_r) begin
            next_seq_r <= next_seq_r + 32'd1;
          end
        end
        ST_SCAN: begin
          idx_r     <= idx_r + 1'b1;
          cmp_vld_r <= 1'b1;
          cmp_idx_r <= idx_r;
          if (!valid_r[idx_r] && !free_found_r) begin
            free_found_r <= 1'b1;
            free_idx_r   <= idx_r;
          end
        end
        ST_DRAIN: begin
          cmp_vld_r <= 1'b0;
        end
        ST_DECIDE: begin
          // The winner leaves the table; a preempted job takes a free slot or its place.
          if (take_best) begin
            valid_r     <= valid_decide;
            run_rec_r   <= best_rec_r;
            run_valid_r <= 1'b1;
          end
        end
        ST_START: begin
          if (run_valid_r) begin
            if (run_rec_r.rem == run_rec_r.rt) begin
              run_rec_r.start <= now_r;
            end
            dv_r  <= 1'b1;
            did_r <= run_rec_r.id;
          end
        end
        ST_ARRIVE: begin
          if (free_found_r) begin
            valid_r[free_idx_r] <= 1'b1;
            next_seq_r          <= next_seq_r + 32'd1;
          end else begin
            tf_r <= 1'b1;
          end
        end
        ST_FIN_A: begin
          ta_r <= (now_r >= run_rec_r.arr) ? now_r - run_rec_r.arr : 32'd0;
          rs_r <= (run_rec_r.start >= run_rec_r.arr)
                ? run_rec_r.start - run_rec_r.arr : 32'd0;
        end
        ST_FIN_B: begin
          if (run_valid_r) begin
            if (done_cnt_r != 16'hFFFF) begin
              done_cnt_r <= done_cnt_r + 16'd1;
            end
            sum_ta_r    <= ta_sum[SUM_W] ? SUM_MAX : ta_sum[SUM_W-1:0];
            sum_wt_r    <= wt_sum[SUM_W] ? SUM_MAX : wt_sum[SUM_W-1:0];
            sum_rs_r    <= rs_sum[SUM_W] ? SUM_MAX : rs_sum[SUM_W-1:0];
            run_valid_r <= 1'b0;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
          end
        end
        default: begin
          cmp_vld_r <= 1'b0;
        end
      endcase
    end
  end

  // Result register, loaded when the previous result has been taken.
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && (!out_valid_r || out_ready)) begin
      out_dispatch_valid   <= dv_r;
      out_dispatch_id      <= did_r;
      out_table_full       <= tf_r;
      out_finished_count   <= done_cnt_r;
      out_total_turnaround <= sum_ta_r;
      out_total_wait       <= sum_wt_r;
      out_total_response   <= sum_rs_r;
    end
  end

endmodule
